FILE: hdl/postfix_stack_evaluator_unit_defines.svh
// Assertion macros shared by the postfix stack evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PSEV_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define PSEV_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define PSEV_ASSERT(name, clk, rst_n, prop)
`define PSEV_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

FILE: hdl/psev_pkg.sv
// Types and constants of the postfix stack evaluator.
package psev_pkg;

	localparam int DATA_W          = 32;
	localparam int NUM_W           = 31;
	localparam int STACK_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		TOK_NUMBER   = 2'd0,
		TOK_OPERATOR = 2'd1,
		TOK_END      = 2'd2,
		TOK_BAD      = 2'd3
	} tok_kind_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} op_code_t;

	// per-cell shift command
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_PREV = 2'd1,
		CELL_NEXT = 2'd2
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DIV  = 1'b1
	} state_t;

	typedef struct packed {
		logic start;
		logic rem_sel;
	} div_req_t;

endpackage

FILE: hdl/psev_cell.sv
// One stack cell: holds a word, or takes it from the neighbor above or below.
module psev_cell
	import psev_pkg::*;
(
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [DATA_W-1:0] prev_data,
	input  logic [DATA_W-1:0] next_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_PREV: data_q <= prev_data;
			CELL_NEXT: data_q <= next_data;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

FILE: hdl/psev_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module psev_div
	import psev_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [DATA_W-1:0] lhs,
	input  logic [DATA_W-1:0] rhs,
	output logic              done,
	output logic [DATA_W-1:0] result
);

	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] LAST_C = CNT_W'(DATA_W - 1);

	logic              busy_q, fin_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q, quo_q, dvs_q, res_q;
	logic              neg_q, rem_sel_q;

	logic [DATA_W:0]   shifted, diff;
	logic [DATA_W-1:0] mag_l, mag_r, mag_res;

	assign mag_l   = lhs[DATA_W-1] ? (~lhs + 1'b1) : lhs;
	assign mag_r   = rhs[DATA_W-1] ? (~rhs + 1'b1) : rhs;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign mag_res = rem_sel_q ? rem_q : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			// last step this cycle: sign fix follows
			fin_q  <= busy_q && !req.start && (cnt_q == LAST_C);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_C)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= mag_l;
			rem_q     <= '0;
			dvs_q     <= mag_r;
			rem_sel_q <= req.rem_sel;
			// remainder takes the dividend's sign
			neg_q     <= req.rem_sel ? lhs[DATA_W-1] : (lhs[DATA_W-1] ^ rhs[DATA_W-1]);
		end else if (busy_q) begin
			rem_q <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
		end
		if (fin_q)
			res_q <= neg_q ? (~mag_res + 1'b1) : mag_res;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: hdl/postfix_stack_evaluator_unit.sv
// Top level of the postfix stack evaluator: token control, cell stack, ALU, output word.
// Evaluates a postfix expression one token word at a time. The operand stack is a row
// of STACK_DEPTH cells with the top in cell 0; a push or a pop shifts the whole row by
// one cell at once. Number, add, subtract, multiply, bad-token and end words are done
// when taken, so the next token can follow. Divide and remainder run through a shared
// one-bit-per-cycle divider in the order start, 32 steps, sign fix, write-back; no token
// is taken meanwhile. An end word loads the output register; further non-end tokens are
// taken while that result waits, an end word waits until the output register is free.
`include "postfix_stack_evaluator_unit_defines.svh"
module postfix_stack_evaluator_unit
	import psev_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [30:0] number_value, [33:31] operator_code, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic        m_tuser    // [0] invalid
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             err_q, err_d;
	logic             out_valid_q;
	logic             out_inv_q;
	logic [31:0]      out_val_q;

	logic             acc, end_take, do_push, do_pop;
	tok_kind_t        func;
	op_code_t         op;
	logic [NUM_W-1:0] num;
	div_req_t         div_req;
	logic             div_done;
	logic [31:0]      div_res, alu_res, load_val;

	logic      [DATA_W-1:0] cell_data [STACK_DEPTH];
	cell_cmd_t              cell_cmd  [STACK_DEPTH];

	assign func = tok_kind_t'(s_tuser);
	assign num  = s_tdata[30:0];
	assign op   = op_code_t'(s_tdata[33:31]);

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready || func != TOK_END);
	assign acc      = s_tvalid && s_tready;

	// rhs sits on top, lhs just below
	always_comb begin
		unique case (op)
			OP_ADD:  alu_res = cell_data[1] + cell_data[0];
			OP_SUB:  alu_res = cell_data[1] - cell_data[0];
			OP_MUL:  alu_res = cell_data[1] * cell_data[0];
			default: alu_res = '0;
		endcase
	end

	assign load_val = do_push ? {1'b0, num} : ((state_q == ST_DIV) ? div_res : alu_res);

	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		err_d           = err_q;
		end_take        = 1'b0;
		do_push         = 1'b0;
		do_pop          = 1'b0;
		div_req.start   = 1'b0;
		div_req.rem_sel = (op == OP_REM);
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (func)
						TOK_END: begin
							end_take = 1'b1;
							count_d  = '0;
							err_d    = 1'b0;
						end
						TOK_NUMBER: begin
							if (!err_q) begin
								if (count_q == DEPTH_C)
									err_d = 1'b1;
								else
									do_push = 1'b1;
							end
						end
						TOK_OPERATOR: begin
							if (!err_q) begin
								if (count_q < TWO_C) begin
									err_d = 1'b1;
								end else begin
									unique case (op) inside
										OP_ADD, OP_SUB, OP_MUL: do_pop = 1'b1;
										OP_DIV, OP_REM: begin
											if (cell_data[0] == '0) begin
												err_d = 1'b1;
											end else begin
												div_req.start = 1'b1;
												state_d       = ST_DIV;
											end
										end
										default: err_d = 1'b1;
									endcase
								end
							end
						end
						default: err_d = 1'b1;
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					do_pop  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (do_push)
			count_d = count_q + ONE_C;
		else if (do_pop)
			count_d = count_q - ONE_C;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q   <= err_d;
			if (end_take)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_take) begin
			out_inv_q <= err_q || (count_q != ONE_C);
			out_val_q <= (err_q || (count_q != ONE_C)) ? '0 : cell_data[0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = out_inv_q;

	// push: everything moves down; pop-and-load: top takes result, rest moves up
	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			logic [DATA_W-1:0] prev_in, next_in;
			if (gi == 0) begin : g_top
				assign prev_in = load_val;
			end else begin : g_mid
				assign prev_in = cell_data[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_bot
				assign next_in = '0;
			end else begin : g_nxt
				assign next_in = cell_data[gi+1];
			end
			always_comb begin
				if (do_push)
					cell_cmd[gi] = CELL_PREV;
				else if (do_pop)
					cell_cmd[gi] = (gi == 0) ? CELL_PREV : CELL_NEXT;
				else
					cell_cmd[gi] = CELL_HOLD;
			end
			psev_cell u_cell (
				.clk       (clk),
				.cmd       (cell_cmd[gi]),
				.prev_data (prev_in),
				.next_data (next_in),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	psev_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.lhs    (cell_data[1]),
		.rhs    (cell_data[0]),
		.done   (div_done),
		.result (div_res)
	);

	`PSEV_ASSERT(a_count_bound, clk, arst_n, count_q <= DEPTH_C)
	`PSEV_ASSERT(a_no_take_in_div, clk, arst_n, (state_q == ST_DIV) |-> !s_tready)
	`PSEV_ASSERT(a_done_in_div, clk, arst_n, div_done |-> (state_q == ST_DIV))
	`PSEV_ASSERT(a_end_gives_word, clk, arst_n, end_take |=> m_tvalid)

endmodule

FILE: tb/psev_result_checker.sv
// Result checker for the postfix stack evaluator: tracks accepted tokens, predicts, compares.
module psev_result_checker
	import psev_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [30:0] number_value, [33:31] operator_code, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] value
	input  logic        m_tuser,   // [0] invalid
	output int          fail_count,
	output int          results_due
);

	typedef struct packed {
		logic              invalid;
		logic [DATA_W-1:0] value;
	} eval_result_t;

	logic [DATA_W-1:0] operands [STACK_DEPTH_DEF];
	int                operand_cnt = 0;
	logic              expr_broken = 1'b0;
	eval_result_t      results_awaited [$];
	int                fails = 0;
	int                pending = 0;

	assign fail_count  = fails;
	assign results_due = pending;

	// truncating signed divide; remainder takes the sign of the dividend
	function automatic logic [DATA_W-1:0] trunc_divide(input logic [DATA_W-1:0] lhs,
			input logic [DATA_W-1:0] rhs, input logic want_rem);
		logic [DATA_W-1:0] mag_l, mag_r, quo, rem;
		mag_l = lhs[DATA_W-1] ? 32'd0 - lhs : lhs;
		mag_r = rhs[DATA_W-1] ? 32'd0 - rhs : rhs;
		quo   = mag_l / mag_r;
		rem   = mag_l % mag_r;
		if (want_rem)
			return lhs[DATA_W-1] ? 32'd0 - rem : rem;
		return (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? 32'd0 - quo : quo;
	endfunction

	task automatic evaluate_token(input tok_kind_t kind, input logic [NUM_W-1:0] num,
			input logic [2:0] op);
		logic [DATA_W-1:0] lhs, rhs;
		eval_result_t      res;
		if (kind == TOK_END) begin
			if (!expr_broken && operand_cnt == 1) begin
				res.invalid = 1'b0;
				res.value   = operands[0];
			end else begin
				res.invalid = 1'b1;
				res.value   = '0;
			end
			results_awaited.push_back(res);
			operand_cnt = 0;
			expr_broken = 1'b0;
			return;
		end
		if (expr_broken)
			return;
		case (kind)
			TOK_NUMBER: begin
				if (operand_cnt >= STACK_DEPTH_DEF) begin
					expr_broken = 1'b1;
				end else begin
					operands[operand_cnt] = {1'b0, num};
					operand_cnt++;
				end
			end
			TOK_OPERATOR: begin
				if (operand_cnt < 2) begin
					expr_broken = 1'b1;
				end else begin
					rhs = operands[operand_cnt-1];
					lhs = operands[operand_cnt-2];
					operand_cnt -= 2;
					case (op)
						OP_ADD: operands[operand_cnt] = lhs + rhs;
						OP_SUB: operands[operand_cnt] = lhs - rhs;
						OP_MUL: operands[operand_cnt] = lhs * rhs;
						OP_DIV, OP_REM: begin
							if (rhs == '0)
								expr_broken = 1'b1;
							else
								operands[operand_cnt] = trunc_divide(lhs, rhs, op == OP_REM);
						end
						default: expr_broken = 1'b1;
					endcase
					if (!expr_broken)
						operand_cnt++;
				end
			end
			default: expr_broken = 1'b1;
		endcase
	endtask

	always @(posedge clk) begin : watch
		eval_result_t want;
		if (arst_n) begin
			// compare before taking this edge's token: its result cannot be out yet
			if (m_tvalid && m_tready) begin
				if (results_awaited.size() == 0) begin
					$error("unexpected result word: invalid=%0b value=%0d",
						m_tuser, $signed(m_tdata));
					fails++;
				end else begin
					want = results_awaited.pop_front();
					if (m_tuser !== want.invalid) begin
						$error("invalid mismatch: expected %0b, got %0b", want.invalid, m_tuser);
						fails++;
					end
					if (m_tdata !== want.value) begin
						$error("value mismatch: expected %0d, got %0d",
							$signed(want.value), $signed(m_tdata));
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready)
				evaluate_token(tok_kind_t'(s_tuser), s_tdata[NUM_W-1:0], s_tdata[33:31]);
			pending = results_awaited.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the postfix stack evaluator: clock, reset, token stimulus, verdict.
module tb_top;
	import psev_pkg::*;

	localparam int TOKEN_TARGET = 1700;
	localparam int CALM_TAIL    = 250;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	int          fail_count;
	int          results_due;

	int          sent       = 0;
	bit          calm       = 1'b0;
	int          stall_odds = 0;

	postfix_stack_evaluator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	psev_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(12 * 600000);
		$display("Verification failed");
		$finish;
	end

	// result side: random stall bursts, none once the tail starts
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm || stall_odds == 0 || $urandom_range(1, stall_odds) != 1) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [NUM_W-1:0] pick_number();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return NUM_W'($urandom_range(0, 9));
			3: return NUM_W'($urandom_range(0, 255));
			4: return NUM_W'(1) << $urandom_range(0, NUM_W-1);
			default: return NUM_W'($urandom);
		endcase
	endfunction

	// drive one token word at the falling edge and hold it until taken
	task automatic put_word(input tok_kind_t kind, input logic [NUM_W-1:0] num,
			input logic [2:0] op);
		if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'd0, op, num};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic push_num(input logic [NUM_W-1:0] num);
		put_word(TOK_NUMBER, num, 3'($urandom));
	endtask

	task automatic apply_op(input logic [2:0] op);
		put_word(TOK_OPERATOR, NUM_W'($urandom), op);
	endtask

	task automatic close_expr();
		put_word(TOK_END, NUM_W'($urandom), 3'($urandom));
	endtask

	// builds most negative over minus one, then divides or takes the remainder
	task automatic min_by_minus_one(input logic [2:0] op);
		push_num(65536);
		push_num(32768);
		apply_op(OP_MUL);
		push_num(0);
		push_num(1);
		apply_op(OP_SUB);
		apply_op(op);
		close_expr();
	endtask

	task automatic well_formed_expr();
		int leaves, pushed, depth;
		leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(1, STACK_DEPTH_DEF)
			: $urandom_range(1, 6);
		pushed = 0;
		depth  = 0;
		while (pushed < leaves || depth > 1) begin
			if (pushed < leaves && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				push_num(pick_number());
				pushed++;
				depth++;
			end else begin
				apply_op(3'($urandom_range(0, 4)));
				depth--;
			end
		end
		close_expr();
	endtask

	task automatic corner_expr();
		case ($urandom_range(0, 3))
			0: min_by_minus_one($urandom_range(0, 1) ? OP_DIV : OP_REM);
			1: begin
				// overflow: more numbers than the stack holds
				repeat (STACK_DEPTH_DEF + $urandom_range(1, 3)) push_num(pick_number());
				close_expr();
			end
			2: begin
				// fills the stack exactly, then folds it down
				repeat (STACK_DEPTH_DEF) push_num(pick_number());
				repeat (STACK_DEPTH_DEF - 1) apply_op(3'($urandom_range(0, 2)));
				close_expr();
			end
			default: begin
				push_num(pick_number());
				push_num(0);
				apply_op($urandom_range(0, 1) ? OP_DIV : OP_REM);
				close_expr();
			end
		endcase
	endtask

	task automatic noise_expr();
		repeat ($urandom_range(1, 8))
			put_word(tok_kind_t'($urandom_range(0, 3)), pick_number(), 3'($urandom));
		close_expr();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = TOK_NUMBER;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// largest literals, multiply and add wrapping
		push_num('1);
		push_num('1);
		apply_op(OP_MUL);
		push_num('1);
		apply_op(OP_ADD);
		close_expr();
		min_by_minus_one(OP_DIV);
		push_num(7);
		push_num(0);
		apply_op(OP_REM);
		close_expr();
		// operator on an empty stack
		apply_op(OP_ADD);
		close_expr();
		// unknown operator code, then a number that must be ignored
		push_num(3);
		push_num(4);
		apply_op(3'd7);
		push_num(5);
		close_expr();
		put_word(TOK_BAD, '0, '0);
		close_expr();

		while (sent < TOKEN_TARGET) begin
			if (sent >= TOKEN_TARGET - CALM_TAIL)
				calm = 1'b1;
			case ($urandom_range(0, 3))
				0: stall_odds = 0;
				1: stall_odds = 3;
				default: stall_odds = 8;
			endcase
			case ($urandom_range(0, 9))
				0: corner_expr();
				1, 2: noise_expr();
				default: well_formed_expr();
			endcase
		end
		s_tvalid <= 1'b0;

		while (results_due != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
